[rtl/core/linear_interp_resampler_unit_macros.svh]
// Assertion macros for the resampler core.
// LIR_ASSERT_CLK names the clock and reset; LIR_ASSERT uses clk_i and rst_ni.
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LIR_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("resampler assertion failed");
`define LIR_ASSERT(label, prop) `LIR_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define LIR_ASSERT_CLK(label, clk, rst_n, prop)
`define LIR_ASSERT(label, prop)
`endif
`endif

[rtl/core/lir_pkg.sv]
package lir_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int RATE_W      = 20;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_W     = 32;
  localparam int DIVIDEND_W  = COUNT_W + RATE_W;
  localparam int DIVISOR_W   = RATE_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO     = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd44100;

  typedef struct packed {
    logic [CMD_W-1:0]              command;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } lir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          frame_valid;
    logic                          final_frame;
  } lir_out_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } lir_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } lir_div_rsp_t;

endpackage

[rtl/core/linear_interp_resampler_unit.sv]
// Linear-interpolation sample-rate converter, stereo out.
// Command channel: present in_item_i with start high; the item transfers at
// the clock edge where start is high and busy is low.
//   LOAD appends one frame to the frame store (ignored once the store is full).
//   RESTART clears the loaded-frame count and the output frame counter.
//   READ produces exactly one result: the next output frame, or a frame with
//   frame_valid low when past the end or when nothing is loaded.
// LOAD and RESTART never raise busy. A READ holds busy until its result is
// out, longer when a frame exists than when it does not. The single shared
// divider, which retires one quotient bit per cycle of a 52-bit dividend,
// runs up to three times per read: output count, source position, and
// fraction. Two frame store reads on the single read port follow, then one
// multiply stage and one add stage.
// Results: result_valid_o is high for exactly one cycle with result_o; the
// receiver cannot stall, so the result is transferred in that cycle.
// Config: cfg_ready_o is always high; write only while busy is low.
// Reset: rates return to 44100 Hz, stereo, counters cleared. The frame store
// is not cleared; entries are only read after they are loaded.
`include "linear_interp_resampler_unit_macros.svh"

module linear_interp_resampler_unit #(
  parameter int MAX_FRAMES = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  lir_pkg::lir_in_t                    in_item_i,
  output logic                                result_valid_o,
  output lir_pkg::lir_out_t                   result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lir_pkg::RATE_W-1:0]          cfg_data_i
);
  import lir_pkg::*;

  localparam int AW     = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int MEM_W  = 2 * SAMPLE_BITS;
  localparam int CPROD_W = CNT_W + RATE_W;
  localparam int CNUM_W = CPROD_W + 2;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int FRACS_W = FRAC_BITS + 1;
  localparam int LERP_W = DIFF_W + FRACS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT_MUL,
    S_CNT_DIV,
    S_CNT_WAIT,
    S_CHECK,
    S_POS_MUL,
    S_POS_DIV,
    S_POS_WAIT,
    S_FRAC_DIV,
    S_FRAC_WAIT,
    S_RD_A,
    S_RD_B,
    S_MUL,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [RATE_W-1:0] in_rate_q;
  logic [RATE_W-1:0] out_rate_q;
  logic              mono_q;

  // Counters
  logic [CNT_W-1:0]   loaded_q;
  logic [COUNT_W-1:0] f_q;

  // Datapath registers
  logic [CPROD_W-1:0]            cnt_prod_q;
  logic [COUNT_W-1:0]            total_q;
  logic [DIVIDEND_W-1:0]         pos_q;
  logic [AW-1:0]                 idx_q;
  logic [RATE_W-1:0]             rem_q;
  logic [FRAC_BITS-1:0]          frac_q;
  logic signed [SAMPLE_BITS-1:0] a_l_q, a_r_q;
  logic signed [LERP_W-1:0]      prod_l_q, prod_r_q;

  logic accept;
  logic do_load;
  logic [CNT_W-1:0]   last;
  logic [AW-1:0]      last_addr;
  logic [AW-1:0]      nxt_addr;
  logic [AW-1:0]      raddr;
  logic [MEM_W-1:0]   rdata;
  logic [CNUM_W-1:0]  cnt_num;
  logic [COUNT_W-1:0] total_d;
  logic [AW-1:0]      idx_d;
  logic               rate_zero;

  logic signed [SAMPLE_BITS-1:0] rd_l, rd_r, b_l, b_r;
  logic signed [DIFF_W-1:0]      diff_l, diff_r;
  logic signed [FRACS_W-1:0]     frac_s;
  logic signed [LERP_W-1:0]      sum_l, sum_r;

  lir_div_req_t div_req;
  lir_div_rsp_t div_rsp;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign do_load     = accept && (in_item_i.command == CMD_LOAD)
                       && (loaded_q < CNT_W'(MAX_FRAMES));
  assign cfg_ready_o = 1'b1;

  // Frame store: {right, left} per entry, written straight from a LOAD.
  lir_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_FRAMES)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (loaded_q[AW-1:0]),
    .wdata_i ({in_item_i.right_sample, in_item_i.left_sample}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lir_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Index clamping: the following frame never goes past the last loaded one.
  assign last      = loaded_q - 1'b1;
  assign last_addr = last[AW-1:0];
  assign nxt_addr  = (idx_q == last_addr) ? idx_q : idx_q + 1'b1;
  assign raddr     = (state_q == S_RD_B) ? nxt_addr : idx_q;
  assign idx_d     = (div_rsp.quotient > DIVIDEND_W'(last)) ? last_addr
                                                            : div_rsp.quotient[AW-1:0];

  // Output count, round half away: (2*loaded*out_rate + in_rate) / (2*in_rate).
  assign cnt_num   = {1'b0, cnt_prod_q, 1'b0} + CNUM_W'(in_rate_q);
  assign rate_zero = (in_rate_q == '0) || (out_rate_q == '0);
  always_comb begin
    if (rate_zero) begin
      total_d = '0;
    end else if (div_rsp.quotient[DIVIDEND_W-1:COUNT_W] != '0) begin
      total_d = '1;
    end else begin
      total_d = div_rsp.quotient[COUNT_W-1:0];
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = pos_q;
    div_req.divisor  = {1'b0, out_rate_q};
    case (state_q)
      S_CNT_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'(cnt_num);
        div_req.divisor  = {in_rate_q, 1'b0};
      end
      S_POS_DIV: begin
        div_req.start = 1'b1;
      end
      S_FRAC_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'({rem_q, {FRAC_BITS{1'b0}}});
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Interpolation: a + floor((b - a) * frac / 2^16); the arithmetic shift
  // gives the floor for negative products.
  assign rd_l   = rdata[SAMPLE_BITS-1:0];
  assign rd_r   = rdata[MEM_W-1:SAMPLE_BITS];
  assign b_l    = rd_l;
  assign b_r    = mono_q ? rd_l : rd_r;
  assign diff_l = DIFF_W'(b_l) - DIFF_W'(a_l_q);
  assign diff_r = DIFF_W'(b_r) - DIFF_W'(a_r_q);
  assign frac_s = signed'({1'b0, frac_q});
  assign sum_l  = LERP_W'(a_l_q) + (prod_l_q >>> FRAC_BITS);
  assign sum_r  = LERP_W'(a_r_q) + (prod_r_q >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CNT_MUL: begin
        cnt_prod_q <= CPROD_W'(loaded_q) * CPROD_W'(out_rate_q);
      end
      S_CNT_WAIT: begin
        if (div_rsp.done) begin
          total_q <= total_d;
        end
      end
      S_POS_MUL: begin
        pos_q <= DIVIDEND_W'(f_q) * DIVIDEND_W'(in_rate_q);
      end
      S_POS_WAIT: begin
        if (div_rsp.done) begin
          idx_q <= idx_d;
          rem_q <= div_rsp.remainder[RATE_W-1:0];
        end
      end
      S_FRAC_WAIT: begin
        if (div_rsp.done) begin
          frac_q <= div_rsp.quotient[FRAC_BITS-1:0];
        end
      end
      S_RD_B: begin
        a_l_q <= rd_l;
        a_r_q <= mono_q ? rd_l : rd_r;
      end
      S_MUL: begin
        prod_l_q <= LERP_W'(diff_l) * LERP_W'(frac_s);
        prod_r_q <= LERP_W'(diff_r) * LERP_W'(frac_s);
      end
      default: begin
        cnt_prod_q <= cnt_prod_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      in_rate_q      <= RATE_RESET;
      out_rate_q     <= RATE_RESET;
      mono_q         <= 1'b0;
      loaded_q       <= '0;
      f_q            <= '0;
      result_valid_o <= 1'b0;
      result_o       <= '0;
    end else begin
      result_valid_o <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_IN_RATE:  in_rate_q  <= cfg_data_i;
          CFG_OUT_RATE: out_rate_q <= cfg_data_i;
          CFG_MONO:     mono_q     <= cfg_data_i[0];
          default:      mono_q     <= mono_q;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (do_load) begin
            loaded_q <= loaded_q + 1'b1;
          end
          if (accept && (in_item_i.command == CMD_RESTART)) begin
            loaded_q <= '0;
            f_q      <= '0;
          end
          if (accept && (in_item_i.command == CMD_READ)) begin
            state_q <= S_CNT_MUL;
          end
        end
        S_CNT_MUL:  state_q <= S_CNT_DIV;
        S_CNT_DIV:  state_q <= S_CNT_WAIT;
        S_CNT_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Drop to an empty frame when past the end or nothing is loaded.
          if ((f_q >= total_q) || (loaded_q == '0)) begin
            result_valid_o <= 1'b1;
            result_o       <= '0;
            state_q        <= S_IDLE;
          end else begin
            state_q <= S_POS_MUL;
          end
        end
        S_POS_MUL:  state_q <= S_POS_DIV;
        S_POS_DIV:  state_q <= S_POS_WAIT;
        S_POS_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_FRAC_DIV;
          end
        end
        S_FRAC_DIV: state_q <= S_FRAC_WAIT;
        S_FRAC_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_RD_A;
          end
        end
        S_RD_A: state_q <= S_RD_B;
        S_RD_B: state_q <= S_MUL;
        S_MUL:  state_q <= S_OUT;
        S_OUT: begin
          result_valid_o       <= 1'b1;
          result_o.left_out    <= sum_l[SAMPLE_BITS-1:0];
          result_o.right_out   <= sum_r[SAMPLE_BITS-1:0];
          result_o.frame_valid <= 1'b1;
          result_o.final_frame <= (f_q == total_q - 1'b1);
          f_q                  <= f_q + 1'b1;
          state_q              <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A result only ever closes a read that was in flight.
  `LIR_ASSERT(a_result_after_busy, result_valid_o |-> $past(busy))
  // A read command always raises busy on the next cycle.
  `LIR_ASSERT(a_read_raises_busy, (accept && in_item_i.command == CMD_READ) |=> busy)
  // A valid frame needs at least one loaded source frame.
  `LIR_ASSERT(a_valid_needs_frames, (result_valid_o && result_o.frame_valid) |-> loaded_q != '0)

endmodule

[rtl/core/lir_ram.sv]
module lir_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/lir_div.sv]
module lir_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lir_pkg::lir_div_req_t req_i,
  output lir_pkg::lir_div_rsp_t rsp_o
);
  import lir_pkg::*;

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  done_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor_q};
    fits    = !diff[DIVISOR_W+1];
    rem_d   = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    quo_d   = {quo_q[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        cnt_q <= DIV_CNT_W'(DIVIDEND_W);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end else if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
